>>> rtl/pss_pkg.sv
// Shared types and codes for the positional sequence store.
package pss_pkg;

    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;
    localparam int CMP_W   = POS_W + 1;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic load;   // capture an accepted command
        logic exec;   // apply it and load the output register
    } pss_ctl_t;

endpackage

>>> rtl/pss_ctrl.sv
// Controller: input/output handshake sequencing for the store.
module pss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pss_pkg::pss_ctl_t ctl
);
    import pss_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept, exec;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // output register must be free (or draining this cycle) before we overwrite it
    assign exec     = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    assign ctl.load = accept;
    assign ctl.exec = exec;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (exec)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/pss_datapath.sv
// Datapath: command register, element cells, count and result register.
module pss_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pss_pkg::pss_ctl_t             ctl,
    input  logic [pss_pkg::CMD_W-1:0]     in_cmd,
    input  logic [pss_pkg::POS_W-1:0]     in_position,
    input  logic signed [pss_pkg::VAL_W-1:0] in_value,
    output logic [pss_pkg::STAT_W-1:0]    out_status,
    output logic signed [pss_pkg::VAL_W-1:0] out_removed_value,
    output logic [pss_pkg::LEN_W-1:0]     out_length
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CMD_W-1:0]        cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;

    logic signed [VAL_W-1:0] elem_reg [DEPTH];
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [STAT_W-1:0]       status_reg, status_next;
    logic signed [VAL_W-1:0] removed_reg, removed_next;
    logic [LEN_W-1:0]        length_reg;

    logic [CMP_W-1:0] pos_ext, cnt_ext;
    logic [POS_W-1:0] pidx;
    logic             pos_zero, ins_ok, del_ok, full;
    logic             do_ins, do_del;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pidx     = pos_reg - POS_W'(1);
    assign pos_zero = (pos_reg == '0);
    assign ins_ok   = !pos_zero && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_ok   = !pos_zero && (pos_ext <= cnt_ext);
    assign full     = (cnt_ext == CMP_W'(DEPTH));

    always_comb begin
        status_next  = STAT_DONE;
        removed_next = '0;
        count_next   = count_reg;
        do_ins       = 1'b0;
        do_del       = 1'b0;
        unique case (cmd_reg)
            CMD_INSERT: begin
                if (!ins_ok) begin
                    status_next = STAT_RANGE;
                end else if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (!del_ok) begin
                    status_next = STAT_RANGE;
                end else begin
                    do_del       = 1'b1;
                    removed_next = elem_reg[pidx[IDX_W-1:0]];
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_cmd;
            pos_reg <= in_position;
            val_reg <= in_value;
        end
        if (ctl.exec) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            length_reg  <= LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.exec) begin
            count_reg <= count_next;
        end
    end

    // each cell compares its own index with the position and takes a neighbor or the new value
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
        logic signed [VAL_W-1:0] up_val, dn_val;
        logic                    take_up, take_dn, take_new;

        if (i > 0) begin : g_up
            assign up_val = elem_reg[i-1];
        end else begin : g_up0
            assign up_val = val_reg;
        end
        if (i < DEPTH - 1) begin : g_dn
            assign dn_val = elem_reg[i+1];
        end else begin : g_dn0
            assign dn_val = elem_reg[i];
        end

        assign take_new = do_ins && (IDX == CMP_W'(pidx));
        assign take_up  = do_ins && (IDX > CMP_W'(pidx)) && (IDX <= cnt_ext);
        assign take_dn  = do_del && (IDX >= CMP_W'(pidx)) && (IDX + CMP_W'(1) < cnt_ext);

        always_ff @(posedge aclk) begin
            if (ctl.exec) begin
                priority if (take_new) begin
                    elem_reg[i] <= val_reg;
                end else if (take_up) begin
                    elem_reg[i] <= up_val;
                end else if (take_dn) begin
                    elem_reg[i] <= dn_val;
                end
            end
        end
    end

    assign out_status        = status_reg;
    assign out_removed_value = removed_reg;
    assign out_length        = length_reg;

endmodule

>>> rtl/positional_sequence_store.sv
// A command is captured on its input transfer and executed into the result
// register once that register is free; the next command waits until it executes.
// All cells shift in parallel within the execute cycle.
// A new command is taken while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous): count and handshake state clear; element
//   cells are not reset and hold no meaning until written.
module positional_sequence_store #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [1:0] cmd, [9:2] position, [41:10] value, rest zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [33:2] removed_value, [38:34] length
);
    import pss_pkg::*;

    pss_ctl_t ctl;

    logic [CMD_W-1:0]        in_cmd;
    logic [POS_W-1:0]        in_position;
    logic signed [VAL_W-1:0] in_value;

    logic [STAT_W-1:0]       out_status;
    logic signed [VAL_W-1:0] out_removed_value;
    logic [LEN_W-1:0]        out_length;

    // unpack the command transfer
    assign in_cmd      = s_tdata[1:0];
    assign in_position = s_tdata[9:2];
    assign in_value    = s_tdata[41:10];

    // controller: sequences capture and execute against the output register
    pss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // datapath: element cells, count, range checks, result register
    pss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .in_cmd            (in_cmd),
        .in_position       (in_position),
        .in_value          (in_value),
        .out_status        (out_status),
        .out_removed_value (out_removed_value),
        .out_length        (out_length)
    );

    // pack the result transfer; pad bits are zero
    assign m_tdata = {1'b0, out_length, out_removed_value, out_status};

endmodule

>>> test/positional_sequence_store_test.sv
// Self-checking stream testbench for the positional sequence store.
`timescale 1ns / 100ps

module positional_sequence_store_test;
    import pss_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASES = 3;

    // Code 3 is not an operation; the block answers it without touching the store.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One command transfer, laid out exactly as s_tdata.
    typedef struct packed {
        logic [5:0]       pad;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic [CMD_W-1:0] cmd;
    } cmd_item_t;

    // One result transfer, laid out exactly as m_tdata.
    typedef struct packed {
        logic              pad;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  removed;
        logic [STAT_W-1:0] status;
    } result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // [1:0] cmd, [9:2] position, [41:10] value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;        // [1:0] status, [33:2] removed_value, [38:34] length

    cmd_item_t pending_cmds[$];
    result_t   expected_results[$];

    // Shadow of the store, advanced once per accepted command.
    logic [VAL_W-1:0] store_vals [DEPTH];
    int               store_len = 0;

    // Length the generator assumes, so it can aim positions at valid slots.
    int gen_len = 0;
    int phase_items = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;

    positional_sequence_store #(.DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Apply one command to the shadow store and return the result it must produce.
    function automatic result_t apply_command(cmd_item_t item);
        result_t r;
        int      p;
        r = '0;
        r.status = STAT_DONE;
        p = item.position;
        case (item.cmd)
            CMD_INSERT: begin
                if (p == 0 || p > store_len + 1) begin
                    r.status = STAT_RANGE;
                end else if (store_len >= DEPTH) begin
                    // position is checked first, so only a valid slot reports full
                    r.status = STAT_FULL;
                end else begin
                    for (int k = store_len; k > p - 1; k--)
                        store_vals[k] = store_vals[k-1];
                    store_vals[p-1] = item.value;
                    store_len++;
                end
            end
            CMD_DELETE: begin
                if (p == 0 || p > store_len) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.removed = store_vals[p-1];
                    for (int k = p - 1; k < store_len - 1; k++)
                        store_vals[k] = store_vals[k+1];
                    store_len--;
                end
            end
            CMD_CLEAR: store_len = 0;
            default: ;
        endcase
        r.length = store_len[LEN_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            errors++;
        end
    endfunction

    // Driver: on a transfer the command goes to the predictor, then the next
    // pending command is offered unless the sender idles this cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_command(cmd_item_t'(s_tdata)));
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("removed_value", want.removed, got.removed);
                check_field("length", 32'(want.length), 32'(got.length));
            end
        end
    end

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, int position, logic [VAL_W-1:0] value);
        cmd_item_t item;
        item = '0;
        item.cmd = cmd;
        item.position = position[POS_W-1:0];
        item.value = value;
        pending_cmds.push_back(item);
        // keep the generator's idea of the length in step
        case (cmd)
            CMD_INSERT:
                if (position != 0 && position <= gen_len + 1 && gen_len < DEPTH) gen_len++;
            CMD_DELETE:
                if (position != 0 && position <= gen_len) gen_len--;
            CMD_CLEAR: gen_len = 0;
            default: ;
        endcase
        if (cmd != CMD_UNUSED) phase_items++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Directed opening: refusals on an empty store, head/middle/tail edits,
    // the unused code and the widest positions.
    task automatic queue_directed();
        queue_cmd(CMD_CLEAR, 0, '0);
        queue_cmd(CMD_DELETE, 1, '0);
        queue_cmd(CMD_INSERT, 0, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 2, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 1, 32'h7FFF_FFFF);
        queue_cmd(CMD_INSERT, 2, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 1, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 2, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 6, 32'hA5A5_A5A5);
        queue_cmd(CMD_DELETE, 0, '0);
        queue_cmd(CMD_DELETE, 5, '0);
        queue_cmd(CMD_DELETE, 2, '0);
        queue_cmd(CMD_DELETE, 3, '0);
        queue_cmd(CMD_DELETE, 1, '0);
        queue_cmd(CMD_UNUSED, 255, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 255, 32'h5A5A_5A5A);
        queue_cmd(CMD_DELETE, 255, '0);
        queue_cmd(CMD_INSERT, 2, 32'h0F0F_0F0F);
        queue_cmd(CMD_CLEAR, 0, '0);
        queue_cmd(CMD_CLEAR, 255, 32'hFFFF_FFFF);
    endtask

    // One random run: mostly well-formed list building and editing, some noise.
    task automatic queue_random_run();
        int kind;
        int n;
        int r;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            // build from the tail or the head; runs past DEPTH hit the full case
            queue_cmd(CMD_CLEAR, $urandom_range(0, 255), pick_value());
            n = $urandom_range(1, DEPTH + 3);
            repeat (n) queue_cmd(CMD_INSERT, (kind < 2) ? gen_len + 1 : 1, pick_value());
        end else if (kind < 8) begin
            n = $urandom_range(4, 20);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 45 || (r < 85 && gen_len == 0))
                    queue_cmd(CMD_INSERT, $urandom_range(1, gen_len + 1), pick_value());
                else if (r < 85)
                    queue_cmd(CMD_DELETE, $urandom_range(1, gen_len), pick_value());
                else if (r < 89)
                    queue_cmd(CMD_INSERT, ($urandom_range(0, 3) == 0) ? 0
                              : $urandom_range(gen_len + 2, 255), pick_value());
                else if (r < 93)
                    queue_cmd(CMD_DELETE, ($urandom_range(0, 3) == 0) ? 0
                              : $urandom_range(gen_len + 1, 255), pick_value());
                else if (r < 96)
                    queue_cmd(CMD_CLEAR, $urandom_range(0, 255), pick_value());
                else
                    queue_cmd(CMD_UNUSED, $urandom_range(0, 255), pick_value());
            end
        end else begin
            n = $urandom_range(2, 8);
            repeat (n) queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 11; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_items = 0;
            if (ph == 0) queue_directed();
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) queue_random_run();
            // the next phase starts only once the block has answered everything
            while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(posedge aclk);
        end

        // wait past the pipeline depth to catch stray results
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> positional_sequence_store.f
rtl/pss_pkg.sv
rtl/pss_ctrl.sv
rtl/pss_datapath.sv
rtl/positional_sequence_store.sv
test/positional_sequence_store_test.sv
